/* rtl/crfp_pkg.sv */
// ----------------------------------------------------------------------------
// crfp_pkg
// Types, codes and constants shared by the camera reply frame parser.
// ----------------------------------------------------------------------------
package crfp_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned KEPT      = 6;
  localparam int unsigned KEPT_IDX_W = 3;
  localparam int unsigned POS_W     = 16;

  localparam logic [BYTE_W-1:0]  TERM_BYTE = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Upper nibbles of header and message bytes
  localparam logic [3:0] HDR_NIB_A   = 4'h9;
  localparam logic [3:0] HDR_NIB_B   = 4'hA;
  localparam logic [3:0] MSG_NIB_ACK = 4'h4;
  localparam logic [3:0] MSG_NIB_DONE = 4'h5;
  localparam logic [3:0] MSG_NIB_ERR = 4'h6;

  typedef enum logic [1:0] {
    KIND_ACK  = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_UNK  = 2'd3
  } kind_t;

  // Snapshot of a terminated frame, as seen by the decoder
  typedef struct packed {
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
    logic [BYTE_W-1:0] b3;
    logic [BYTE_W-1:0] b4;
    logic [BYTE_W-1:0] b5;
    logic              len_ge3;
    logic              len_ge4;
    logic              len_ge7;
  } frame_t;

  typedef struct packed {
    logic              frame_ok;
    kind_t             reply_kind;
    logic [3:0]        socket_num;
    logic [BYTE_W-1:0] err_code;
    logic [POS_W-1:0]  lens_position;
    logic [BYTE_W-1:0] power_state;
  } result_t;

endpackage

/* rtl/crfp_collect.sv */
// ----------------------------------------------------------------------------
// crfp_collect
// Byte counter and store for the first six bytes of the current frame.
// ----------------------------------------------------------------------------
module crfp_collect (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       byte_fire,
  input  logic [crfp_pkg::BYTE_W-1:0] rx_byte,
  output logic                       term_fire,
  output crfp_pkg::frame_t           frame
);

  logic [crfp_pkg::COUNT_W-1:0] count_r;
  logic [crfp_pkg::COUNT_W-1:0] count_nxt;
  logic [crfp_pkg::BYTE_W-1:0]  bytes_r [crfp_pkg::KEPT];
  logic                         is_term;
  logic                         store_en;

  assign is_term   = (rx_byte == crfp_pkg::TERM_BYTE);
  assign term_fire = byte_fire && is_term;
  assign store_en  = byte_fire && !is_term &&
                     (count_r < crfp_pkg::COUNT_W'(crfp_pkg::KEPT));

  always_comb begin
    count_nxt = count_r;
    if (byte_fire) begin
      if (is_term) begin
        count_nxt = '0;
      end else if (count_r != crfp_pkg::COUNT_MAX) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  // Payload store, guarded by the length flags on read
  always_ff @(posedge clk) begin
    if (store_en) begin
      bytes_r[count_r[crfp_pkg::KEPT_IDX_W-1:0]] <= rx_byte;
    end
  end

  // Frame length counts the terminator: L >= n means count >= n - 1
  always_comb begin
    frame.b0      = bytes_r[0];
    frame.b1      = bytes_r[1];
    frame.b2      = bytes_r[2];
    frame.b3      = bytes_r[3];
    frame.b4      = bytes_r[4];
    frame.b5      = bytes_r[5];
    frame.len_ge3 = (count_r >= crfp_pkg::COUNT_W'(2));
    frame.len_ge4 = (count_r >= crfp_pkg::COUNT_W'(3));
    frame.len_ge7 = (count_r >= crfp_pkg::COUNT_W'(6));
  end

endmodule

/* rtl/crfp_decode.sv */
// ----------------------------------------------------------------------------
// crfp_decode
// Header check, reply classification and sticky kind, socket and error state.
// ----------------------------------------------------------------------------
module crfp_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              term_fire,
  input  crfp_pkg::frame_t  frame,
  output crfp_pkg::result_t result
);

  crfp_pkg::kind_t   kind_r;
  crfp_pkg::kind_t   kind_nxt;
  logic [3:0]        socket_r;
  logic [3:0]        socket_nxt;
  logic [crfp_pkg::BYTE_W-1:0] error_r;
  logic [crfp_pkg::BYTE_W-1:0] error_nxt;
  logic              hdr_ok;
  logic              ok;
  logic [crfp_pkg::POS_W-1:0]  pos;

  assign hdr_ok = (frame.b0[7:4] == crfp_pkg::HDR_NIB_A) ||
                  (frame.b0[7:4] == crfp_pkg::HDR_NIB_B);
  assign ok     = frame.len_ge3 && hdr_ok;

  always_comb begin
    kind_nxt   = kind_r;
    socket_nxt = socket_r;
    error_nxt  = error_r;
    if (ok) begin
      unique case (frame.b1[7:4])
        crfp_pkg::MSG_NIB_ACK: begin
          kind_nxt   = crfp_pkg::KIND_ACK;
          socket_nxt = frame.b1[3:0];
        end
        crfp_pkg::MSG_NIB_DONE: begin
          kind_nxt   = crfp_pkg::KIND_DONE;
          socket_nxt = frame.b1[3:0];
        end
        crfp_pkg::MSG_NIB_ERR: begin
          kind_nxt   = crfp_pkg::KIND_ERR;
          socket_nxt = frame.b1[3:0];
          if (frame.len_ge4) begin
            error_nxt = frame.b2;
          end
        end
        default: begin
          kind_nxt = crfp_pkg::KIND_UNK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r   <= crfp_pkg::KIND_UNK;
      socket_r <= '0;
      error_r  <= '0;
    end else if (term_fire) begin
      kind_r   <= kind_nxt;
      socket_r <= socket_nxt;
      error_r  <= error_nxt;
    end
  end

  // Position is the 16-bit OR of b2[3:0] << 12, b3 << 8, b4 << 4 and b5
  assign pos = {frame.b2[3:0], 12'h000} |
               {frame.b3, 8'h00} |
               {4'h0, frame.b4, 4'h0} |
               {8'h00, frame.b5};

  always_comb begin
    result.frame_ok      = ok;
    result.reply_kind    = kind_nxt;
    result.socket_num    = socket_nxt;
    result.err_code      = error_nxt;
    result.lens_position = frame.len_ge7 ? pos : '0;
    result.power_state   = frame.len_ge4 ? frame.b2 : '0;
  end

endmodule

/* rtl/crfp_skid.sv */
// ----------------------------------------------------------------------------
// crfp_skid
// Result register with one skid entry, so the input side runs on under stall.
// ----------------------------------------------------------------------------
module crfp_skid (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  crfp_pkg::result_t push_data,
  output logic              space,
  output logic              out_valid,
  input  logic              out_ready,
  output crfp_pkg::result_t out_data
);

  logic              out_valid_r;
  crfp_pkg::result_t out_data_r;
  logic              skid_valid_r;
  crfp_pkg::result_t skid_data_r;
  logic              drain;

  assign drain     = out_ready || !out_valid_r;
  assign space     = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (drain) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push) begin
        out_data_r <= push_data;
      end
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

endmodule

/* rtl/camera_reply_frame_parser.sv */
// ----------------------------------------------------------------------------
// camera_reply_frame_parser
// Parses camera control reply frames byte by byte and gives one result per
// 0xFF terminator.
// ----------------------------------------------------------------------------
//
//   channel  | direction | tdata                        | tuser
//   ---------+-----------+------------------------------+---------------------
//   in_      | slave     | [7:0] rx_byte                | -
//   out_     | master    | socket, error, position, pwr | frame_ok, reply_kind
//
// One byte is taken in every cycle while in_tready is high. A terminator's
// result is registered and appears on the out_ side in the cycle after the
// byte is accepted when the output register is empty or drains in that
// cycle; otherwise it waits in the skid entry. Other bytes give no result.
// in_tready is set by the skid entry of the result register: it falls only
// when a result is held in the output register and a second one is waiting.
// Reset (rst_n low, synchronous) clears the byte count, the sticky state
// (reply kind unknown, socket and error zero) and both result entries.
//
module camera_reply_frame_parser (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [3:0] socket_num, [11:4] err_code,
                                  // [27:12] lens_position,
                                  // [35:28] power_state, [39:36] zero
  output logic [2:0]  out_tuser   // [0] frame_ok, [2:1] reply_kind
);

  logic              byte_fire;
  logic              term_fire;
  logic              space;
  crfp_pkg::frame_t  frame;
  crfp_pkg::result_t result;
  crfp_pkg::result_t out_res;

  // Accept a byte whenever the skid entry is free
  assign in_tready = space;
  assign byte_fire = in_tvalid && in_tready;

  // Count and hold the first six bytes of the running frame
  crfp_collect u_collect (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_fire (byte_fire),
    .rx_byte   (in_tdata),
    .term_fire (term_fire),
    .frame     (frame)
  );

  // Check header and length, classify, advance the sticky fields
  crfp_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .term_fire (term_fire),
    .frame     (frame),
    .result    (result)
  );

  // Hold the result until the downstream side takes it
  crfp_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (term_fire),
    .push_data (result),
    .space     (space),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tdata = {4'h0, out_res.power_state, out_res.lens_position,
                      out_res.err_code, out_res.socket_num};
  assign out_tuser = {out_res.reply_kind, out_res.frame_ok};

endmodule
